### hw/rtl/fpsws_pkg.sv
// ----------------------------------------------------------------------------
// fpsws_pkg
// Shared types, constants and constant tables for the Fourier partial sum
// waveform synthesizer: register map, microcode word, sine and weight tables.
// ----------------------------------------------------------------------------
package fpsws_pkg;

  localparam int MAX_HARMONICS_DEF = 64;
  localparam int PHASE_BITS_DEF    = 16;
  localparam int HARM_LIMIT        = 256;   // largest supported term count
  localparam int SAMPLE_W          = 22;
  localparam int ACC_W             = 48;
  localparam int WEIGHT_W          = 25;
  localparam int SINE_W            = 17;
  localparam int MAG_W             = 25;
  localparam int GAIN_W            = 25;
  localparam int AMP_W             = 12;
  localparam int P1_W              = MAG_W + GAIN_W;
  localparam int P2_W              = P1_W + AMP_W;

  localparam logic [GAIN_W-1:0] GAIN_SQUARE = 25'd21361415;  // 4/pi in Q24
  localparam logic [GAIN_W-1:0] GAIN_SAW    = 25'd10680707;  // 2/pi in Q24
  localparam logic [GAIN_W-1:0] GAIN_TRI    = 25'd13599099;  // 8/pi^2 in Q24

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SQUARE = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_TRI    = 2'd2
  } wave_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_COUNT = 2'd1,
    REG_AMP   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [6:0]       count;
    logic [AMP_W-1:0] amp;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_TERM,
    OP_ROUND,
    OP_GAIN,
    OP_AMP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_OUT_BUSY
  } hold_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_TERMS,
    JMP_MORE_TERMS
  } jump_t;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_INIT,
    STEP_LOOP,
    STEP_DRAIN0,
    STEP_DRAIN1,
    STEP_ROUND,
    STEP_GAIN,
    STEP_AMP,
    STEP_EMIT
  } step_t;

  typedef struct packed {
    dp_op_t op;
    hold_t  hold;
    jump_t  jump;
    step_t  target;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic no_terms;
    logic more_terms;
    logic out_busy;
  } dp_status_t;

  typedef logic [15:0]         sine_tbl_t [0:256];
  typedef logic [WEIGHT_W-1:0] wt_tbl_t   [0:HARM_LIMIT-1];

  // Unsigned long division by shift and subtract, used only while the
  // constant tables are built.
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine in Q15, from a degree-13 Taylor series in Q30.
  function automatic sine_tbl_t build_sine_table();
    sine_tbl_t       tbl;
    longint unsigned jx;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    for (int j = 0; j <= 256; j++) begin
      jx = longint'(j);
      x  = (jx * HALF_PI_Q30 + 64'd128) >> 8;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd156);
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd110);
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd72);
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd42);
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd20);
      t  = Q30_ONE - const_div((x2 * t) >> 30, 64'd6);
      s  = (x * t) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      tbl[j] = 16'(q);
    end
    return tbl;
  endfunction

  // Per-term weights in Q24, round(2^24 / m), indexed by term number minus one.
  function automatic wt_tbl_t build_weight_table(input wave_t wave);
    wt_tbl_t         tbl;
    longint unsigned kk;
    longint unsigned h;
    longint unsigned m;
    for (int i = 0; i < HARM_LIMIT; i++) begin
      kk = longint'(i + 1);
      h  = (wave == WAVE_SAW) ? kk : (2 * kk - 1);
      m  = (wave == WAVE_TRI) ? h * h : h;
      tbl[i] = WEIGHT_W'(const_div((64'd1 << 24) + (m >> 1), m));
    end
    return tbl;
  endfunction

endpackage

### hw/rtl/fourier_partial_sum_wave_synth.sv
// ----------------------------------------------------------------------------
// fourier_partial_sum_wave_synth
// Truncated Fourier series synthesizer for square, sawtooth and triangle
// waves, run by a microcoded sequencer over a multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid/in_ready) carries a
// phase, a fraction of one period. The result channel (out_valid/out_ready)
// returns one signed sample per request, the partial sum times the amplitude
// times 256, saturated to 22 bits. The APB-style port sets the waveform (byte
// address 0), the number of terms K (address 4) and the amplitude (address
// 8); write it only while no request is in flight.
// Timing: a request is taken in the idle step, then one init step, one step
// per term (the term loop of the control program, one multiply-accumulate a
// cycle), two steps to drain the product pipeline, and rounding, gain,
// amplitude and output steps; with no terms to sum, the init step jumps
// straight to rounding. The result is registered in the output step, and a
// new request is taken only once the sequencer is back in its idle step.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and computed, and only its output step waits.
// Reset returns the sequencer to idle, empties the output register and
// loads the registers with square wave, 8 terms, amplitude 1024.
// ----------------------------------------------------------------------------
module fourier_partial_sum_wave_synth import fpsws_pkg::*; #(
  parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
  parameter int PHASE_BITS    = PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_phase,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [3:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t       cfg;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  // Configuration registers, read live by the datapath.
  fpsws_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The sequencer steps through the control program; the input is taken
  // only in its idle step.
  fpsws_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // The datapath carries out one operation per step and reports the loop
  // and output conditions back to the sequencer.
  fpsws_dpath #(
    .MAX_HARMONICS (MAX_HARMONICS),
    .PHASE_BITS    (PHASE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .in_phase   (in_phase),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .status     (status)
  );

endmodule

### hw/rtl/fpsws_regs.sv
// ----------------------------------------------------------------------------
// fpsws_regs
// APB-style configuration registers: waveform mode, term count, amplitude.
// ----------------------------------------------------------------------------
module fpsws_regs import fpsws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [1:0]       mode_r;
  logic [6:0]       count_r;
  logic [AMP_W-1:0] amp_r;
  logic             wr_en;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= WAVE_SQUARE;
      count_r <= 7'd8;
      amp_r   <= 12'd1024;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_MODE:  mode_r  <= cfg_pwdata[1:0];
        REG_COUNT: count_r <= cfg_pwdata[6:0];
        REG_AMP:   amp_r   <= cfg_pwdata[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MODE:  cfg_prdata = {30'd0, mode_r};
      REG_COUNT: cfg_prdata = {25'd0, count_r};
      REG_AMP:   cfg_prdata = {20'd0, amp_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.mode  = mode_r;
  assign cfg.count = count_r;
  assign cfg.amp   = amp_r;

endmodule

### hw/rtl/fpsws_useq.sv
// ----------------------------------------------------------------------------
// fpsws_useq
// Microcode sequencer: step counter, control ROM, hold and jump logic.
// ----------------------------------------------------------------------------
module fpsws_useq import fpsws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   held;
  logic   take;

  // Control program. Each word names a datapath operation, a condition that
  // keeps the step in place, and a conditional jump.
  always_comb begin
    case (step_r)
      STEP_IDLE:   uw = '{OP_LOAD,  HOLD_NO_INPUT, JMP_NEVER,      STEP_IDLE};
      STEP_INIT:   uw = '{OP_INIT,  HOLD_NONE,     JMP_NO_TERMS,   STEP_ROUND};
      STEP_LOOP:   uw = '{OP_TERM,  HOLD_NONE,     JMP_MORE_TERMS, STEP_LOOP};
      STEP_DRAIN0: uw = '{OP_NONE,  HOLD_NONE,     JMP_NEVER,      STEP_IDLE};
      STEP_DRAIN1: uw = '{OP_NONE,  HOLD_NONE,     JMP_NEVER,      STEP_IDLE};
      STEP_ROUND:  uw = '{OP_ROUND, HOLD_NONE,     JMP_NEVER,      STEP_IDLE};
      STEP_GAIN:   uw = '{OP_GAIN,  HOLD_NONE,     JMP_NEVER,      STEP_IDLE};
      STEP_AMP:    uw = '{OP_AMP,   HOLD_NONE,     JMP_NEVER,      STEP_IDLE};
      STEP_EMIT:   uw = '{OP_EMIT,  HOLD_OUT_BUSY, JMP_ALWAYS,     STEP_IDLE};
      default:     uw = '{OP_NONE,  HOLD_NONE,     JMP_ALWAYS,     STEP_IDLE};
    endcase
  end

  always_comb begin
    case (uw.hold)
      HOLD_NO_INPUT: held = !in_valid;
      HOLD_OUT_BUSY: held = status.out_busy;
      default:       held = 1'b0;
    endcase
    case (uw.jump)
      JMP_ALWAYS:     take = 1'b1;
      JMP_NO_TERMS:   take = status.no_terms;
      JMP_MORE_TERMS: take = status.more_terms;
      default:        take = 1'b0;
    endcase
    ctrl.op = held ? OP_NONE : uw.op;
    if (held) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_t'(step_r + 4'd1);
    end
  end

  assign in_ready = (uw.hold == HOLD_NO_INPUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (step_r == STEP_INIT))
    else $error("accepted request did not start the program");

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_LOOP && !status.more_terms) |=> (step_r == STEP_DRAIN0))
    else $error("term loop did not exit after its last term");

endmodule

### hw/rtl/fpsws_dpath.sv
// ----------------------------------------------------------------------------
// fpsws_dpath
// Datapath: harmonic phase stepping, sine and weight lookup, pipelined
// multiply-accumulate, rounding, gain and amplitude scaling, output register.
// ----------------------------------------------------------------------------
module fpsws_dpath import fpsws_pkg::*; #(
  parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
  parameter int PHASE_BITS    = PHASE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_ctrl_t                   ctrl,
  input  cfg_t                       cfg,
  input  logic [15:0]                in_phase,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output dp_status_t                 status
);

  localparam int CW = $clog2(MAX_HARMONICS + 1);
  localparam int IW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

  localparam sine_tbl_t SINE_TBL = build_sine_table();
  localparam wt_tbl_t   W_SQ     = build_weight_table(WAVE_SQUARE);
  localparam wt_tbl_t   W_SAW    = build_weight_table(WAVE_SAW);
  localparam wt_tbl_t   W_TRI    = build_weight_table(WAVE_TRI);

  logic [PHASE_BITS-1:0]          ph_r;
  logic [PHASE_BITS-1:0]          hp_r;
  logic [CW-1:0]                  n_r;
  logic [CW-1:0]                  cnt_r;
  logic [WEIGHT_W-1:0]            w_r;
  logic signed [SINE_W-1:0]       s_r;
  logic                           tv_r;
  logic signed [WEIGHT_W+SINE_W:0] prod_r;
  logic                           pv_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic                           neg_r;
  logic [MAG_W-1:0]               mag_r;
  logic [P1_W-1:0]                p1_r;
  logic [P2_W-1:0]                p2_r;
  logic                           out_valid_r;
  logic [SAMPLE_W-1:0]            out_sample_r;

  logic [9:0]            aidx;
  logic [8:0]            sidx;
  logic [15:0]           qsin;
  logic                  term_neg;
  logic signed [SINE_W-1:0] sine_val;
  logic [WEIGHT_W-1:0]   wsel;
  logic [IW-1:0]         tidx;
  logic [PHASE_BITS-1:0] hp_step;
  logic [CW-1:0]         cnt_init;
  logic [ACC_W-1:0]      acc_abs;
  logic [ACC_W:0]        acc_rnd;
  logic [GAIN_W-1:0]     gain;
  logic [P2_W:0]         p2_rnd;
  logic [30:0]           res;
  logic [SAMPLE_W-1:0]   sample_nxt;
  logic                  out_busy;

  // Top ten bits of the harmonic phase form the angle index.
  generate
    if (PHASE_BITS >= 10) begin : g_idx_trunc
      assign aidx = hp_r[PHASE_BITS-1 -: 10];
    end else begin : g_idx_pad
      assign aidx = {hp_r, {(10 - PHASE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    sidx     = aidx[8] ? (9'd256 - {1'b0, aidx[7:0]}) : {1'b0, aidx[7:0]};
    qsin     = SINE_TBL[sidx];
    // Second half of the period and alternating-sign series both flip the term.
    term_neg = aidx[9] ^ ((cfg.mode != WAVE_SQUARE) && n_r[0]);
    sine_val = term_neg ? -$signed({1'b0, qsin}) : $signed({1'b0, qsin});
    tidx     = n_r[IW-1:0];
    case (cfg.mode)
      WAVE_SQUARE: wsel = W_SQ[tidx];
      WAVE_SAW:    wsel = W_SAW[tidx];
      WAVE_TRI:    wsel = W_TRI[tidx];
      default:     wsel = '0;
    endcase
    case (cfg.mode)
      WAVE_SQUARE: gain = GAIN_SQUARE;
      WAVE_SAW:    gain = GAIN_SAW;
      WAVE_TRI:    gain = GAIN_TRI;
      default:     gain = '0;
    endcase
    hp_step = (cfg.mode == WAVE_SAW) ? ph_r : PHASE_BITS'({ph_r, 1'b0});
    if (cfg.mode != WAVE_SQUARE && cfg.mode != WAVE_SAW && cfg.mode != WAVE_TRI) begin
      cnt_init = '0;
    end else if (int'(cfg.count) > MAX_HARMONICS) begin
      cnt_init = CW'(MAX_HARMONICS);
    end else begin
      cnt_init = CW'(cfg.count);
    end
    acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    acc_rnd = {1'b0, acc_abs} + (ACC_W+1)'(1 << 22);
    p2_rnd  = {1'b0, p2_r} + (P2_W+1)'(64'd1 << 31);
    res     = p2_rnd[62:32];
    if (neg_r) begin
      sample_nxt = (res > 31'd2097152) ? 22'h200000 : SAMPLE_W'(~res + 31'd1);
    end else begin
      sample_nxt = (res > 31'd2097151) ? 22'h1FFFFF : SAMPLE_W'(res);
    end
  end

  assign out_busy          = out_valid_r && !out_ready;
  assign status.out_busy   = out_busy;
  assign status.no_terms   = (cnt_init == '0);
  assign status.more_terms = (({1'b0, n_r} + (CW+1)'(1)) < {1'b0, cnt_r});

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: ph_r <= PHASE_BITS'(in_phase);
      OP_INIT: begin
        hp_r  <= ph_r;
        n_r   <= '0;
        cnt_r <= cnt_init;
      end
      OP_TERM: begin
        w_r  <= wsel;
        s_r  <= sine_val;
        hp_r <= hp_r + hp_step;
        n_r  <= n_r + CW'(1);
      end
      OP_ROUND: begin
        neg_r <= acc_r[ACC_W-1];
        mag_r <= MAG_W'(acc_rnd >> 23);
      end
      OP_GAIN: p1_r <= P1_W'(mag_r) * P1_W'(gain);
      OP_AMP:  p2_r <= P2_W'(p1_r) * P2_W'(cfg.amp);
      OP_EMIT: out_sample_r <= sample_nxt;
      default: begin
      end
    endcase
    prod_r <= $signed({1'b0, w_r}) * s_r;
    if (ctrl.op == OP_INIT) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tv_r <= (ctrl.op == OP_TERM);
      pv_r <= tv_r;
      if (ctrl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = $signed(out_sample_r);

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> !out_busy)
    else $error("result written over an unaccepted result");

  a_mac_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r |=> pv_r)
    else $error("fetched term did not reach the product stage");

endmodule

### tb/tb_fourier_partial_sum_wave_synth.sv
// ----------------------------------------------------------------------------
// tb_fourier_partial_sum_wave_synth
// Self-checking bench for the Fourier partial sum synthesizer. A bit-exact
// predictor mirrors the sine table, weights, gain and rounding, and every
// returned sample is compared against it. Registers are reprogrammed over
// the APB-style port between batches. Both channels see random idling, and
// the result channel is held off for long stretches to back up the block.
// ----------------------------------------------------------------------------
module tb_fourier_partial_sum_wave_synth;
  timeunit 1ns;
  timeprecision 1ps;
  import fpsws_pkg::*;

  // The instance is built with these values, and the predictor assumes them.
  localparam int TERM_CAP = 64;
  localparam int PHASE_W  = 16;

  // Waveform code 3 is not a member of wave_t, but the register accepts it.
  localparam logic [1:0] WAVE_UNUSED = 2'd3;
  // Register index with no register behind it (byte address 12).
  localparam int unsigned REG_SPARE = 3;

  // Waveform gains in Q24.
  localparam longint unsigned Q24_FOUR_OVER_PI    = 64'd21361415;
  localparam longint unsigned Q24_TWO_OVER_PI     = 64'd10680707;
  localparam longint unsigned Q24_EIGHT_OVER_PI_SQ = 64'd13599099;

  localparam longint unsigned ONE_Q30        = 64'd1073741824;
  localparam longint unsigned HALF_PI_IN_Q30 = 64'd1686629713;
  localparam longint unsigned SAT_POS_MAG    = 64'd2097151;
  localparam longint unsigned SAT_NEG_MAG    = 64'd2097152;

  // Once every sample is back the block is already idle, so a short
  // settle is enough.
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 100;
  // Long hold-off on the result channel, well above two full computations.
  localparam int STALL_CYCLES   = 500;
  // Cycles without any accepted request, returned sample or register access before giving up.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BATCHES = 26;
  localparam int BATCH_ITEMS    = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [15:0]                phase;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_expect_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [15:0]                in_phase    = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [3:0]                 cfg_paddr   = '0;
  logic [31:0]                cfg_pwdata  = '0;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;

  // Shadow copy of the registers, starting from their reset values.
  logic [1:0]  cur_mode  = WAVE_SQUARE;
  logic [6:0]  cur_terms = 7'd8;
  logic [11:0] cur_amp   = 12'd1024;

  // Quarter-wave sine in Q15, filled once before reset is released.
  longint quarter_sine_tbl [0:256];

  logic [15:0]    phases_to_send [$];
  sample_expect_t samples_due [$];
  sample_expect_t due;

  int error_count   = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 59;
  int stall_requests = 0;
  int stalls_taken   = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  fourier_partial_sum_wave_synth #(
    .MAX_HARMONICS (TERM_CAP),
    .PHASE_BITS    (PHASE_W)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_phase    (in_phase),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Expected sample for one phase under the current register settings.
  // Terms are summed exactly in Q39, the magnitude is rounded to Q16, scaled
  // by gain and amplitude, rounded to Q8 and saturated with its sign restored.
  function automatic logic signed [SAMPLE_W-1:0] synth_sample(input logic [15:0] ph);
    int unsigned     terms;
    int unsigned     k;
    int unsigned     idx;
    longint unsigned gain;
    longint unsigned h;
    longint unsigned m;
    longint unsigned w;
    longint unsigned hp;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned res;
    longint          sine;
    longint          term;
    longint          acc;
    logic            neg;
    terms = (cur_terms > TERM_CAP) ? TERM_CAP : cur_terms;
    case (cur_mode)
      WAVE_SQUARE: gain = Q24_FOUR_OVER_PI;
      WAVE_SAW:    gain = Q24_TWO_OVER_PI;
      WAVE_TRI:    gain = Q24_EIGHT_OVER_PI_SQ;
      default: begin
        // The unused waveform code sums nothing.
        gain  = 0;
        terms = 0;
      end
    endcase
    acc = 0;
    for (k = 1; k <= terms; k++) begin
      h  = (cur_mode == WAVE_SAW) ? k : 2 * k - 1;
      m  = (cur_mode == WAVE_TRI) ? h * h : h;
      w  = ((64'd1 << 24) + m / 2) / m;
      hp = (h * ph) & 64'hFFFF;
      // Ten-bit angle: quadrant in the top two bits, table offset below.
      idx = 32'((hp >> (PHASE_W - 10)) & 64'd1023);
      case (idx >> 8)
        0:       sine =  quarter_sine_tbl[idx & 255];
        1:       sine =  quarter_sine_tbl[256 - (idx & 255)];
        2:       sine = -quarter_sine_tbl[idx & 255];
        default: sine = -quarter_sine_tbl[256 - (idx & 255)];
      endcase
      term = longint'(w) * sine;
      if (cur_mode != WAVE_SQUARE && (k % 2) == 0) begin
        term = -term;
      end
      acc += term;
    end
    neg  = (acc < 0);
    mag  = neg ? -acc : acc;
    mag  = (mag + (64'd1 << 22)) >> 23;
    prod = mag * gain * cur_amp;
    res  = (prod + (64'd1 << 31)) >> 32;
    if (neg) begin
      if (res > SAT_NEG_MAG) begin
        res = SAT_NEG_MAG;
      end
      return SAMPLE_W'(-longint'(res));
    end
    if (res > SAT_POS_MAG) begin
      res = SAT_POS_MAG;
    end
    return SAMPLE_W'(res);
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  // The shadow copy keeps only the bits that the register holds.
  task automatic apb_write(input int unsigned idx, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(idx * 4);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode  = data[1:0];
      REG_COUNT: cur_terms = data[6:0];
      REG_AMP:   cur_amp   = data[11:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, sometimes with junk above the used bits.
  task automatic program_regs(input logic [1:0] mode, input logic [6:0] terms,
                              input logic [11:0] amp);
    apb_write(REG_MODE,  {($urandom_range(3) == 0) ? 30'($urandom) : 30'd0, mode});
    apb_write(REG_COUNT, {($urandom_range(3) == 0) ? 25'($urandom) : 25'd0, terms});
    apb_write(REG_AMP,   {($urandom_range(3) == 0) ? 20'($urandom) : 20'd0, amp});
    @(negedge clk);
  endtask

  // Queues up to eight phases packed first-to-last from the top bits down.
  task automatic queue_phases(input int n, input logic [16*8-1:0] words);
    for (int i = 0; i < n; i++) begin
      phases_to_send.push_back(words[16*(n-1-i) +: 16]);
    end
  endtask

  // Waits until every request has been sent and answered, then lets the
  // block settle before the registers may be touched again.
  task automatic drain();
    do @(negedge clk);
    while (phases_to_send.size() != 0 || in_valid || samples_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: predicts the sample of each accepted request and offers the next
  // phase whenever the channel is free, skipping cycles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        samples_due.push_back('{phase: in_phase, sample: synth_sample(in_phase)});
      end
      if (!in_valid || in_ready) begin
        if (phases_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_phase <= phases_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each returned sample against the oldest prediction and
  // drives out_ready, including the long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (samples_due.size() == 0) begin
          if (error_count < MAX_REPORTS) begin
            $display("unexpected sample %0d with no request outstanding", out_sample);
          end
          error_count++;
        end else begin
          due = samples_due.pop_front();
          if (out_sample !== due.sample) begin
            if (error_count < MAX_REPORTS) begin
              $display("sample mismatch for phase 0x%04h: expected %0d, got %0d",
                       due.phase, due.sample, out_sample);
            end
            error_count++;
          end
        end
      end
      if (stall_requests != stalls_taken) begin
        stalls_taken = stall_requests;
        stall_left   = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_fourier_partial_sum_wave_synth failed");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned j;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q;
    int              pick;
    logic [1:0]      mode;
    logic [6:0]      terms;
    logic [11:0]     amp;
    logic [15:0]     ph;

    // Quarter-wave sine: degree-13 Taylor series in Q30 by Horner's rule,
    // the divisors being 13*12, 11*10, ... 3*2, then rounded to Q15.
    for (j = 0; j <= 256; j++) begin
      x  = (j * HALF_PI_IN_Q30 + 64'd128) >> 8;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        t = ONE_Q30 - ((x2 * t) >> 30) / ((12 - 2 * i) * (13 - 2 * i));
      end
      s = (x * t) >> 30;
      q = (s + 64'd16384) >> 15;
      quarter_sine_tbl[j] = (q > 64'd32768) ? 32768 : q;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings (square wave, 8 terms, amplitude 1024) at phase
    // extremes and the quadrant boundaries.
    queue_phases(6, {16'h0000, 16'hFFFF, 16'h4000, 16'hC000, 16'h0001, 16'h8000});
    drain();

    // Sawtooth at the largest term count and full amplitude.
    program_regs(WAVE_SAW, 7'd64, 12'd4095);
    queue_phases(4, {16'h0001, 16'h7FFF, 16'hFFFF, 16'h2AAB});
    drain();

    // Triangle with a count above the term cap, which clamps to 64.
    program_regs(WAVE_TRI, 7'd127, 12'd4095);
    queue_phases(3, {16'h0000, 16'h4000, 16'hC000});
    drain();

    // The unused waveform code must give zero whatever the phase.
    program_regs(WAVE_UNUSED, 7'd1, 12'd4095);
    queue_phases(2, {16'h4000, 16'h1234});
    drain();

    // Zero terms: nothing summed, so zero out.
    program_regs(WAVE_SQUARE, 7'd0, 12'd2048);
    queue_phases(2, {16'h4000, 16'hBEEF});
    drain();

    // Zero amplitude.
    program_regs(WAVE_SQUARE, 7'd1, 12'd0);
    queue_phases(1, {16'h4000});
    drain();

    // A write to the spare index must leave every register untouched.
    program_regs(WAVE_TRI, 7'd3, 12'd4095);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_phases(2, {16'h4000, 16'h5555});
    drain();

    // Random batches, each under freshly drawn register settings. The idle
    // pattern flips a third of the way in and stops two thirds in.
    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      if (b == RANDOM_BATCHES / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 32;
      end else if (b == 2 * RANDOM_BATCHES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick = $urandom_range(15);
      mode = (pick < 5) ? WAVE_SQUARE : (pick < 10) ? WAVE_SAW :
             (pick < 15) ? WAVE_TRI : WAVE_UNUSED;

      // Mostly short sums keep the run quick; some long and clamped ones.
      pick = $urandom_range(9);
      if (pick < 6) begin
        terms = 7'($urandom_range(16, 1));
      end else if (pick < 8) begin
        terms = 7'($urandom_range(64, 17));
      end else if (pick == 8) begin
        terms = 7'($urandom_range(127, 65));
      end else begin
        terms = ($urandom_range(1) == 0) ? 7'd0 : 7'd64;
      end

      pick = $urandom_range(9);
      if (pick < 7) begin
        amp = 12'($urandom);
      end else if (pick == 7) begin
        amp = 12'd0;
      end else if (pick == 8) begin
        amp = 12'd4095;
      end else begin
        amp = 12'($urandom_range(15, 1));
      end

      program_regs(mode, terms, amp);

      // Twice in the run the receiver stops for a long stretch while the
      // sender keeps offering, so the block fills and drops in_ready.
      if (b == 4 || b == RANDOM_BATCHES - 4) begin
        stall_requests++;
      end

      for (int i = 0; i < BATCH_ITEMS; i++) begin
        pick = $urandom_range(19);
        case (pick)
          0:       ph = 16'h0000;
          1:       ph = 16'hFFFF;
          2:       ph = {2'($urandom_range(3)), 14'h0000};
          3:       ph = 16'($urandom_range(63));
          4:       ph = 16'hFFFF - 16'($urandom_range(63));
          default: ph = 16'($urandom);
        endcase
        phases_to_send.push_back(ph);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && samples_due.size() == 0) begin
      $display("tb_fourier_partial_sum_wave_synth passed");
    end else begin
      $display("tb_fourier_partial_sum_wave_synth failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fpsws_pkg.sv
hw/rtl/fpsws_regs.sv
hw/rtl/fpsws_useq.sv
hw/rtl/fpsws_dpath.sv
hw/rtl/fourier_partial_sum_wave_synth.sv
tb/tb_fourier_partial_sum_wave_synth.sv
